/* hdl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam int unsigned ChunkSizeBitsDefault = 32;
  localparam int unsigned MaxBodyWidth         = 25;
  localparam logic [MaxBodyWidth-1:0] MaxBodyReset = 25'd1048576;

  localparam logic [7:0] CharLf = 8'h0a;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       new_message;
  } item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       finished;
    logic [1:0] error_code;
  } result_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/hcbd_in_reg.sv */
// ----------------------------------------------------------------------------
// hcbd_in_reg
// Input register: captures one beat and holds it until the decode step takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hcbd_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 held_valid,
  output hcbd_pkg::item_t      held_item
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/hcbd_step.sv */
// ----------------------------------------------------------------------------
// hcbd_step
// Framing state and next-state logic: one raw byte in, one result out per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step #(
  parameter int unsigned ChunkSizeBits = hcbd_pkg::ChunkSizeBitsDefault
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 advance,
  input  wire hcbd_pkg::item_t                      item,
  input  wire logic [hcbd_pkg::MaxBodyWidth-1:0]    max_body_bytes,
  output hcbd_pkg::result_t                         result
);

  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_TRAIL = 3'd2;
  localparam logic [2:0] PH_FINAL = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;

  logic [2:0]                        phase, phase_next;
  logic [ChunkSizeBits-1:0]          chunk_remaining, chunk_remaining_next;
  logic                              hex_ended, hex_ended_next;
  logic [hcbd_pkg::MaxBodyWidth-1:0] body_count, body_count_next;
  logic [1:0]                        error_seen, error_seen_next;

  always_comb begin
    logic [2:0]                        ph;
    logic [ChunkSizeBits-1:0]          chunk;
    logic                              hend;
    logic [hcbd_pkg::MaxBodyWidth-1:0] cnt;
    logic [1:0]                        err;
    logic [4:0]                        hex;
    logic [ChunkSizeBits-1:0]          chunk_dec;

    ph    = phase;
    chunk = chunk_remaining;
    hend  = hex_ended;
    cnt   = body_count;
    err   = error_seen;
    hex   = hcbd_pkg::hex_digit(item.data_byte);
    chunk_dec = chunk_remaining - ChunkSizeBits'(1);

    result.body_byte  = 8'd0;
    result.byte_valid = 1'b0;

    // New message restarts framing before this byte is looked at.
    if (item.new_message) begin
      ph    = PH_SIZE;
      chunk = '0;
      hend  = 1'b0;
      cnt   = '0;
      err   = hcbd_pkg::ERR_NONE;
    end

    if (ph == PH_DONE || ph == PH_ERROR) begin
      // hold until the next message
    end else if (item.end_of_stream) begin
      if (ph == PH_FINAL) begin
        ph = PH_DONE;
      end else begin
        ph  = PH_ERROR;
        err = hcbd_pkg::ERR_MALFORMED;
      end
    end else begin
      case (ph)
        PH_SIZE: begin
          if (item.data_byte == hcbd_pkg::CharLf) begin
            ph   = (chunk == '0) ? PH_FINAL : PH_DATA;
            hend = 1'b0;
          end else if (!hend) begin
            if (!hex[4]) begin
              hend = 1'b1;
            end else if (|chunk[ChunkSizeBits-1 -: 4]) begin
              // size no longer fits: saturate
              chunk = '1;
            end else begin
              chunk = {chunk[ChunkSizeBits-5:0], hex[3:0]};
            end
          end
        end
        PH_DATA: begin
          if (cnt < max_body_bytes) begin
            result.body_byte  = item.data_byte;
            result.byte_valid = 1'b1;
            cnt   = cnt + hcbd_pkg::MaxBodyWidth'(1);
            chunk = chunk_dec;
            if (chunk_dec == '0) begin
              ph = PH_TRAIL;
            end
          end else begin
            ph  = PH_ERROR;
            err = hcbd_pkg::ERR_TOO_LARGE;
          end
        end
        PH_TRAIL: begin
          if (item.data_byte == hcbd_pkg::CharLf) begin
            ph    = PH_SIZE;
            chunk = '0;
            hend  = 1'b0;
          end
        end
        PH_FINAL: begin
          if (item.data_byte == hcbd_pkg::CharLf) begin
            ph = PH_DONE;
          end
        end
        default: begin
          ph  = PH_ERROR;
          err = hcbd_pkg::ERR_MALFORMED;
        end
      endcase
    end

    phase_next           = ph;
    chunk_remaining_next = chunk;
    hex_ended_next       = hend;
    body_count_next      = cnt;
    error_seen_next      = err;

    result.finished   = (ph == PH_DONE);
    result.error_code = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      hex_ended       <= 1'b0;
      body_count      <= '0;
      error_seen      <= hcbd_pkg::ERR_NONE;
    end else if (advance) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      hex_ended       <= hex_ended_next;
      body_count      <= body_count_next;
      error_seen      <= error_seen_next;
    end
  end

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && !item.new_message && (phase == PH_DONE || phase == PH_ERROR))
    |=> ($stable(phase) && $stable(error_seen)))
    else $error("stopped decoder changed state");

  a_byte_only_in_data: assert property (@(posedge clk) disable iff (rst)
    result.byte_valid |-> (phase == PH_DATA && !item.new_message))
    else $error("body byte delivered outside data phase");

  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    (result.error_code != hcbd_pkg::ERR_NONE) |-> (phase_next == PH_ERROR))
    else $error("error reported without stopping");

  a_done_or_error: assert property (@(posedge clk) disable iff (rst)
    !(result.finished && result.error_code != hcbd_pkg::ERR_NONE))
    else $error("finished together with an error");

endmodule

`default_nettype wire

/* hdl/hcbd_out_reg.sv */
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire hcbd_pkg::result_t load_result,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hcbd_pkg::result_t      out_result
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_result <= load_result;
    end
  end

endmodule

`default_nettype wire

/* hdl/http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips chunked transfer framing from a raw body byte stream.
// ----------------------------------------------------------------------------
// An accepted beat sits in the input register, then its result is registered.
// Throughput: one byte per cycle unless stalled; framing updates in a single pass.
// A stalled output holds the result register and backs up into the input one.
// Reset (rst, synchronous): framing state cleared, both stages empty,
// max_body_bytes back to 1048576.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned ChunkSizeBits = hcbd_pkg::ChunkSizeBitsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hcbd_pkg::MaxBodyWidth-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        data_byte,
  input  wire logic                              end_of_stream,
  input  wire logic                              new_message,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             body_byte,
  output logic                                   byte_valid,
  output logic                                   finished,
  output logic [1:0]                             error_code
);

  logic [hcbd_pkg::MaxBodyWidth-1:0] max_body_bytes;
  hcbd_pkg::item_t   in_item, held_item;
  hcbd_pkg::result_t step_result, out_result;
  logic              held_valid, can_load, advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= hcbd_pkg::MaxBodyReset;
    end else if (cfg_valid && cfg_ready) begin
      max_body_bytes <= cfg_data;
    end
  end

  assign in_item.data_byte     = data_byte;
  assign in_item.end_of_stream = end_of_stream;
  assign in_item.new_message   = new_message;

  assign advance = held_valid && can_load;

  hcbd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .advance   (advance),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  hcbd_step #(
    .ChunkSizeBits(ChunkSizeBits)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (held_item),
    .max_body_bytes(max_body_bytes),
    .result        (step_result)
  );

  hcbd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (held_valid),
    .load_result(step_result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign body_byte  = out_result.body_byte;
  assign byte_valid = out_result.byte_valid;
  assign finished   = out_result.finished;
  assign error_code = out_result.error_code;

endmodule

`default_nettype wire

/* verif/tb_http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking bench for the chunked body decoder. Whole chunked messages
// with random sizes, extensions and payloads go in, mixed with truncated,
// corrupted and noise streams. An in-bench model of the framing predicts
// every result beat, and the bench compares each beat field by field.
// The body limit register is rewritten between phases, including 1 and 16777216.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned NumPhases     = 8;

  typedef enum logic [2:0] {
    FR_SIZE, FR_DATA, FR_TRAIL, FR_LAST, FR_DONE, FR_ERROR
  } frame_t;

  // Framing model plus the queue of result beats still in flight.
  class decoded_beat_board;
    frame_t            frame;
    logic [31:0]       chunk_left;
    bit                digits_over;
    logic [24:0]       body_count;
    logic [1:0]        err_state;
    logic [24:0]       body_limit;
    hcbd_pkg::result_t expected_q[$];
    int unsigned       mismatches;

    function new();
      body_limit = hcbd_pkg::MaxBodyReset;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      frame       = FR_SIZE;
      chunk_left  = '0;
      digits_over = 1'b0;
      body_count  = '0;
      err_state   = hcbd_pkg::ERR_NONE;
    endfunction

    function void set_limit(logic [24:0] v);
      body_limit = v;
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    // Returns 1 when the beat was not ignored by a finished or failed body.
    function bit take_raw_byte(hcbd_pkg::item_t it);
      hcbd_pkg::result_t r;
      int                d;
      bit                live;
      logic [31:0]       top;
      if (it.new_message) clear();
      live = (frame != FR_DONE && frame != FR_ERROR);
      r = '0;
      top = '1;
      if (!live) begin
        // hold everything until a new message
      end else if (it.end_of_stream) begin
        if (frame == FR_LAST) begin
          frame = FR_DONE;
        end else begin
          frame = FR_ERROR;
          err_state = hcbd_pkg::ERR_MALFORMED;
        end
      end else begin
        case (frame)
          FR_SIZE: begin
            if (it.data_byte == hcbd_pkg::CharLf) begin
              frame = (chunk_left == 0) ? FR_LAST : FR_DATA;
              digits_over = 1'b0;
            end else if (!digits_over) begin
              d = hex_of(it.data_byte);
              if (d < 0) begin
                digits_over = 1'b1;
              end else if (chunk_left > ((top - 32'(d)) >> 4)) begin
                chunk_left = top;
              end else begin
                chunk_left = (chunk_left << 4) + 32'(d);
              end
            end
          end
          FR_DATA: begin
            if (body_count < body_limit) begin
              r.body_byte  = it.data_byte;
              r.byte_valid = 1'b1;
              body_count   = body_count + 25'd1;
              chunk_left   = chunk_left - 32'd1;
              if (chunk_left == 0) frame = FR_TRAIL;
            end else begin
              frame = FR_ERROR;
              err_state = hcbd_pkg::ERR_TOO_LARGE;
            end
          end
          FR_TRAIL: begin
            if (it.data_byte == hcbd_pkg::CharLf) begin
              frame       = FR_SIZE;
              chunk_left  = '0;
              digits_over = 1'b0;
            end
          end
          FR_LAST: begin
            if (it.data_byte == hcbd_pkg::CharLf) frame = FR_DONE;
          end
          default: begin
            frame = FR_ERROR;
            err_state = hcbd_pkg::ERR_MALFORMED;
          end
        endcase
      end
      r.finished   = (frame == FR_DONE);
      r.error_code = err_state;
      expected_q.push_back(r);
      return live;
    endfunction

    function void check_decoded(hcbd_pkg::result_t got);
      hcbd_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte %h valid %b fin %b err %0d",
                   got.body_byte, got.byte_valid, got.finished, got.error_code);
        return;
      end
      want = expected_q.pop_front();
      if (got.body_byte !== want.body_byte || got.byte_valid !== want.byte_valid ||
          got.finished !== want.finished || got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp/got: byte %h/%h valid %b/%b fin %b/%b err %0d/%0d",
                   want.body_byte, got.body_byte, want.byte_valid, got.byte_valid,
                   want.finished, got.finished, want.error_code, got.error_code);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [hcbd_pkg::MaxBodyWidth-1:0] cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [7:0]                        data_byte = '0;
  logic                              end_of_stream = 1'b0;
  logic                              new_message = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [7:0]                        body_byte;
  logic                              byte_valid;
  logic                              finished;
  logic [1:0]                        error_code;

  decoded_beat_board board = new();
  hcbd_pkg::item_t   raw_q[$];
  hcbd_pkg::result_t seen_beat;
  bit                calm = 1'b0;
  int unsigned       live_items = 0;
  int unsigned       cycle_count = 0;

  http_chunked_body_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .new_message  (new_message),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .body_byte    (body_byte),
    .byte_valid   (byte_valid),
    .finished     (finished),
    .error_code   (error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check each accepted result beat, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_beat.body_byte  = body_byte;
      seen_beat.byte_valid = byte_valid;
      seen_beat.finished   = finished;
      seen_beat.error_code = error_code;
      board.check_decoded(seen_beat);
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == hcbd_pkg::CharLf) b = " ";
    return b;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    hcbd_pkg::item_t it;
    it.data_byte     = b;
    it.end_of_stream = 1'b0;
    it.new_message   = 1'b0;
    raw_q.push_back(it);
  endfunction

  function automatic void add_eos();
    hcbd_pkg::item_t it;
    it.data_byte     = 8'($urandom_range(0, 255));
    it.end_of_stream = 1'b1;
    it.new_message   = 1'b0;
    raw_q.push_back(it);
  endfunction

  function automatic void add_line_end();
    if ($urandom_range(0, 9) != 0) add_byte("\r");
    add_byte(hcbd_pkg::CharLf);
  endfunction

  // Hex size in mixed case, optional leading zero and extension.
  function automatic void add_size_line(int unsigned sz);
    int unsigned nibs[$];
    int unsigned v;
    int unsigned k;
    v = sz;
    do begin
      nibs.push_front(v % 16);
      v = v / 16;
    end while (v != 0);
    for (k = $urandom_range(0, 3); k > 2; k--) nibs.push_front(0);
    foreach (nibs[i]) begin
      if (nibs[i] < 10) add_byte(8'("0" + nibs[i]));
      else if ($urandom_range(0, 1) != 0) add_byte(8'("a" + nibs[i] - 10));
      else add_byte(8'("A" + nibs[i] - 10));
    end
    if ($urandom_range(0, 3) == 0) begin
      add_byte(";");
      for (k = $urandom_range(0, 4); k > 0; k--) add_byte(line_byte());
    end
    add_line_end();
  endfunction

  function automatic void make_message();
    int unsigned chunks;
    int unsigned sz;
    int unsigned k;
    int unsigned cut;
    raw_q.delete();
    chunks = $urandom_range(0, 3);
    for (int c = 0; c < chunks; c++) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      add_size_line(sz);
      for (k = 0; k < sz; k++) add_byte(8'($urandom_range(0, 255)));
      for (k = $urandom_range(0, 5); k > 3; k--) add_byte(line_byte());
      add_line_end();
    end
    // last chunk: zero size, sometimes a line with no digits at all
    if ($urandom_range(0, 5) == 0) add_line_end();
    else add_size_line(0);
    if ($urandom_range(0, 4) == 0) begin
      add_eos();
    end else begin
      for (k = $urandom_range(0, 6); k > 3; k--) add_byte(line_byte());
      add_line_end();
    end
    for (k = $urandom_range(0, 4); k > 2; k--) add_byte(8'($urandom_range(0, 255)));
    // break some messages: truncate or corrupt one byte
    if ($urandom_range(0, 4) == 0 && raw_q.size() > 2) begin
      cut = $urandom_range(1, raw_q.size() - 1);
      while (raw_q.size() > cut) void'(raw_q.pop_back());
      add_eos();
    end else if ($urandom_range(0, 9) == 0) begin
      raw_q[$urandom_range(0, raw_q.size() - 1)].data_byte = 8'($urandom_range(0, 255));
    end
    raw_q[0].new_message = 1'b1;
  endfunction

  task automatic push_raw(input hcbd_pkg::item_t it);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= it.data_byte;
    end_of_stream <= it.end_of_stream;
    new_message   <= it.new_message;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (board.take_raw_byte(it)) live_items++;
  endtask

  task automatic send_queue();
    foreach (raw_q[i]) push_raw(raw_q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write the body limit; only called once the decoder is idle.
  task automatic write_limit(input logic [24:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_limit(v);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [24:0]     limit_val;
    int unsigned     phase_goal;
    hcbd_pkg::item_t noise;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one byte chunk, empty size line ending the body, close on the last line
    raw_q.delete();
    add_byte("1"); add_byte(hcbd_pkg::CharLf); add_byte(8'hff); add_byte("\r");
    add_byte(hcbd_pkg::CharLf);
    add_byte(hcbd_pkg::CharLf); add_eos(); add_byte("A");
    raw_q[0].new_message = 1'b1;
    send_queue();
    // oversized hex size saturates, then the stream closes mid data
    raw_q.delete();
    for (int k = 0; k < 9; k++) add_byte((k % 2 == 0) ? "f" : "F");
    add_byte(hcbd_pkg::CharLf); add_byte(8'h00); add_eos();
    raw_q[0].new_message = 1'b1;
    send_queue();
    // close at once
    raw_q.delete();
    add_eos();
    raw_q[0].new_message = 1'b1;
    send_queue();
    // bare line feed as size line, then one trailer line
    raw_q.delete();
    add_byte(hcbd_pkg::CharLf); add_byte("x"); add_byte(hcbd_pkg::CharLf);
    raw_q[0].new_message = 1'b1;
    send_queue();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: limit_val = 25'd16777216;
        1: limit_val = 25'd1;
        2: limit_val = 25'($urandom_range(1, 64));
        3: limit_val = hcbd_pkg::MaxBodyReset;
        4: limit_val = 25'($urandom_range(2, 30));
        5: limit_val = 25'd16777216;
        6: limit_val = 25'd1;
        default: limit_val = 25'($urandom_range(1, 300));
      endcase
      write_limit(limit_val);
      calm = (p == 3);
      phase_goal = live_items + ItemsPerPhase;
      while (live_items < phase_goal) begin
        if ($urandom_range(0, 9) == 0) begin
          noise.data_byte     = 8'($urandom_range(0, 255));
          noise.end_of_stream = ($urandom_range(0, 3) == 0);
          noise.new_message   = ($urandom_range(0, 3) == 0);
          push_raw(noise);
        end else begin
          make_message();
          send_queue();
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
